### rtl/star_stencil_2d_radius3_defines.svh
// assertion macros for the star stencil block
// used by the top level only; expects clk and rst_n in the including scope
`ifndef STAR_STENCIL_2D_RADIUS3_DEFINES_SVH
`define STAR_STENCIL_2D_RADIUS3_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("star stencil: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("star stencil: next-cycle check failed");

`endif

### rtl/ss2r3_pkg.sv
// constants and types for the radius-3 star stencil
// no dependencies; imported by star_stencil_2d_radius3 and the testbench
package ss2r3_pkg;

    // frame geometry
    localparam int INNER_SIZE = 512;
    localparam int RADIUS     = 3;
    localparam int SIDE       = INNER_SIZE + 2 * RADIUS;
    localparam int TOTAL      = SIDE * SIDE;
    localparam int LAG        = RADIUS * SIDE + RADIUS;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 20;
    localparam int COORD_W  = 10;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_W + 2 * COORD_W + 7) / 8) * 8;

    // internal widths
    localparam int CNT_W   = $clog2(SIDE);
    localparam int POS_W   = $clog2(TOTAL);
    localparam int ADDR_W  = $clog2(SIDE);
    localparam int NROWS   = 2 * RADIUS;
    localparam int LINE_W  = NROWS * SAMPLE_W;
    localparam int NTAP    = 4 * RADIUS + 1;
    localparam int SUM_W   = SAMPLE_W + $clog2(NTAP);
    localparam int GRP     = 5;
    localparam int NGRP    = (NTAP + GRP - 1) / GRP;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // item kinds on tuser
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // per-item control travelling with the data
    typedef struct packed {
        logic               produce;
        logic               border;
        logic               last;
        logic [CNT_W-1:0]   row;
        logic [CNT_W-1:0]   col;
    } ctl_t;

    // one queued result
    typedef struct packed {
        logic                       last;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic signed [VALUE_W-1:0]  value;
    } res_t;

endpackage

### rtl/star_stencil_2d_radius3.sv
// streaming 2-D star stencil of radius 3 over a square raster frame
// depends on ss2r3_pkg and star_stencil_2d_radius3_defines.svh
//
// Usage
//   s_axis: one word per frame position in raster order; tdata is the signed
//   sample, tuser is the kind (pixel or flush). A flush stands in for a zero
//   sample; a flush while no frame is open is taken and dropped.
//   m_axis: one result word per frame position; tdata carries value, row and
//   col, tlast marks the final position of the frame. The result for a
//   position appears once 3 rows plus 3 samples further of input are taken.
//   Throughput: one word per cycle while s_axis_tready is high. Six earlier
//   rows sit in a single line memory of 518 words of 96 bits, read and
//   written back once per word; short shift chains supply the horizontal
//   and vertical taps. A released result word passes the stage 1, 2 and 3
//   registers and the result queue on its way to m_axis.
//   A stalled receiver fills an 8-deep result queue; s_axis_tready drops only
//   when queued plus in-flight results would overrun it, so input keeps
//   flowing while a result waits. Reset clears the counters, pointers and
//   queue; the line memory needs no clearing since no result reads an entry
//   that was never written.
`include "star_stencil_2d_radius3_defines.svh"

module star_stencil_2d_radius3 (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ss2r3_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  logic [0:0]                          s_axis_tuser,  // [0] op
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ss2r3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [19:0] value, [29:20] row,
                                                               // [39:30] col
    output logic                                m_axis_tlast   // frame_last
);

    import ss2r3_pkg::*;

    // input handshake and position control
    logic                       in_hs;
    logic                       is_flush;
    logic                       ignore;
    logic                       act;
    logic signed [SAMPLE_W-1:0] cur;
    ctl_t                       ctl0;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   crow_reg, crow_next;
    logic [CNT_W-1:0]   ccol_reg, ccol_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;

    assign in_hs    = s_axis_tvalid && s_axis_tready;
    assign is_flush = (s_axis_tuser[0] == OP_FLUSH);
    assign ignore   = is_flush && (pos_reg == '0);
    assign act      = in_hs && !ignore;
    assign cur      = is_flush ? '0 : s_axis_tdata[SAMPLE_W-1:0];

    // classify the centre position of this word
    always_comb
    begin
        ctl0.produce = (pos_reg >= POS_W'(LAG));
        ctl0.border  = (crow_reg < CNT_W'(RADIUS)) || (crow_reg >= CNT_W'(SIDE - RADIUS)) ||
                       (ccol_reg < CNT_W'(RADIUS)) || (ccol_reg >= CNT_W'(SIDE - RADIUS));
        ctl0.last    = (crow_reg == CNT_W'(SIDE - 1)) && (ccol_reg == CNT_W'(SIDE - 1));
        ctl0.row     = crow_reg;
        ctl0.col     = ccol_reg;
    end

    // frame position and centre row/column counters
    always_comb
    begin
        pos_next  = pos_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        ptr_next  = ptr_reg;
        if (act)
        begin
            ptr_next = (ptr_reg == ADDR_W'(SIDE - 1)) ? '0 : ptr_reg + 1'b1;
            if (ctl0.produce && ctl0.last)
            begin
                pos_next  = '0;
                crow_next = '0;
                ccol_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (ctl0.produce)
                begin
                    if (ccol_reg == CNT_W'(SIDE - 1))
                    begin
                        ccol_next = '0;
                        crow_next = crow_reg + 1'b1;
                    end
                    else
                    begin
                        ccol_next = ccol_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            ptr_reg  <= ptr_next;
        end
    end

    // stage 1: line memory read issued, word and control held
    logic                       s1_vld_reg;
    logic signed [SAMPLE_W-1:0] cur1_reg;
    ctl_t                       ctl1_reg;
    logic [ADDR_W-1:0]          ptr1_reg;
    logic [LINE_W-1:0]          rd_word_reg;
    logic [LINE_W-1:0]          wr_word;
    logic [LINE_W-1:0]          line_mem [SIDE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= act;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            cur1_reg <= cur;
            ctl1_reg <= ctl0;
            ptr1_reg <= ptr_reg;
        end
    end

    // line memory: each entry holds the six previous rows at one column slot
    assign wr_word = {rd_word_reg[LINE_W-SAMPLE_W-1:0], cur1_reg};

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            line_mem[ptr1_reg] <= wr_word;
        end
        if (act)
        begin
            rd_word_reg <= line_mem[ptr_reg];
        end
    end

    // rows of the column: index 0 is the current word, 2*RADIUS the oldest
    logic signed [SAMPLE_W-1:0] line [NROWS+1];

    always_comb
    begin
        line[0] = cur1_reg;
        for (int k = 1; k <= NROWS; k++)
        begin
            line[k] = rd_word_reg[(k-1)*SAMPLE_W +: SAMPLE_W];
        end
    end

    // column delay chains: vertical taps on all rows but the centre row,
    // the centre row runs twice as long for the horizontal taps
    logic signed [SAMPLE_W-1:0] vsh_reg [NROWS][RADIUS];
    logic signed [SAMPLE_W-1:0] hsh_reg [NROWS];
    logic signed [SAMPLE_W-1:0] taps [NTAP];

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            for (int v = 0; v < NROWS; v++)
            begin
                vsh_reg[v][0] <= line[(v < RADIUS) ? v : v + 1];
                for (int s = 1; s < RADIUS; s++)
                begin
                    vsh_reg[v][s] <= vsh_reg[v][s-1];
                end
            end
            hsh_reg[0] <= line[RADIUS];
            for (int s = 1; s < NROWS; s++)
            begin
                hsh_reg[s] <= hsh_reg[s-1];
            end
        end
    end

    // tap selection before the chains move on
    always_comb
    begin
        for (int v = 0; v < NROWS; v++)
        begin
            taps[v] = vsh_reg[v][RADIUS-1];
        end
        taps[NROWS] = line[RADIUS];
        for (int j = 1; j <= NROWS; j++)
        begin
            taps[NROWS + j] = hsh_reg[j-1];
        end
    end

    // stage 2: taps registered
    logic                       s2_vld_reg;
    ctl_t                       ctl2_reg;
    logic signed [SAMPLE_W-1:0] taps2_reg [NTAP];
    logic signed [SAMPLE_W-1:0] centre2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg && ctl1_reg.produce;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl2_reg    <= ctl1_reg;
        centre2_reg <= hsh_reg[RADIUS-1];
        for (int t = 0; t < NTAP; t++)
        begin
            taps2_reg[t] <= taps[t];
        end
    end

    // stage 3: partial sums over small groups of taps
    logic signed [SUM_W-1:0] grp_sum [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_sum[g] = '0;
            for (int e = 0; e < GRP; e++)
            begin
                if (g * GRP + e < NTAP)
                begin
                    grp_sum[g] = grp_sum[g] + SUM_W'(taps2_reg[g * GRP + e]);
                end
            end
        end
    end

    logic                       s3_vld_reg;
    ctl_t                       ctl3_reg;
    logic signed [SUM_W-1:0]    part3_reg [NGRP];
    logic signed [SAMPLE_W-1:0] centre3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl3_reg    <= ctl2_reg;
        centre3_reg <= centre2_reg;
        for (int g = 0; g < NGRP; g++)
        begin
            part3_reg[g] <= grp_sum[g];
        end
    end

    // final sum and border copy
    logic signed [SUM_W-1:0] star_sum;
    res_t                    res3;

    always_comb
    begin
        star_sum = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            star_sum = star_sum + part3_reg[g];
        end
        res3.value = ctl3_reg.border ? VALUE_W'(centre3_reg) : VALUE_W'(star_sum);
        res3.row   = COORD_W'(ctl3_reg.row);
        res3.col   = COORD_W'(ctl3_reg.col);
        res3.last  = ctl3_reg.last;
    end

    // result queue with credit on in-flight words
    res_t                   fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]     fcnt_reg, fcnt_next;
    logic                   pop;
    logic [1:0]             pending;
    logic [FIFO_CW:0]       used;
    res_t                   head;

    assign pending = 2'(s1_vld_reg && ctl1_reg.produce) + 2'(s2_vld_reg) + 2'(s3_vld_reg);
    assign used    = (FIFO_CW+1)'(fcnt_reg) + (FIFO_CW+1)'(pending);
    assign s_axis_tready = (used < (FIFO_CW+1)'(FIFO_DEPTH));

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = s3_vld_reg ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fcnt_next   = fcnt_reg + FIFO_CW'(s3_vld_reg) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fcnt_reg   <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_vld_reg)
        begin
            fifo_mem[wr_ptr_reg] <= res3;
        end
    end

    // output word
    assign m_axis_tvalid = (fcnt_reg != '0);
    assign m_axis_tdata  = OUT_TDATA_W'({head.col, head.row, head.value});
    assign m_axis_tlast  = head.last;

    // checks
    `SS_ASSERT_IMP(a_no_overrun, 1'b1, used <= (FIFO_CW+1)'(FIFO_DEPTH))
    `SS_ASSERT_IMP(a_rw_apart, s1_vld_reg && act, ptr1_reg != ptr_reg)
    `SS_ASSERT_NEXT(a_idle_flush, in_hs && ignore, $stable(pos_reg) && $stable(ptr_reg))

endmodule

### sim/testbench.sv
// self-checking testbench for star_stencil_2d_radius3: the opening of a 518x518 frame
// a scoreboard class predicts every result word from the accepted input words and checks them in order
// depends on ss2r3_pkg and the star_stencil_2d_radius3 rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ss2r3_pkg::*;

    // history of samples needed for the deepest vertical tap
    localparam int HIST_DEPTH     = 2 * RADIUS * SIDE + RADIUS;
    // stimulus shape
    localparam int LEAD_FLUSHES   = 3;
    localparam int FRAME_ITEMS    = LAG + 100;
    localparam int OPENING_N      = 13;
    localparam int FLUSH_AT       = 12;
    localparam int PATCH_ROW_LO   = 8;
    localparam int PATCH_ROW_HI   = 16;
    localparam int N_ITEMS        = LEAD_FLUSHES + FRAME_ITEMS;
    // idling and run length
    localparam int MAX_IDLE       = 40;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam longint LIMIT_CYCLES = longint'(N_ITEMS) * (2 * MAX_IDLE + 8) * 3;

    // one result word, split into its fields
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic                      last;
    } stencil_word_t;

    // predicts the stencil output and checks result words in order
    class stencil_scoreboard;
        logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
        int unsigned                hist_wr;
        int unsigned                frame_pos;
        stencil_word_t              words_due [$];
        int unsigned                errors;
        int unsigned                border_words;
        int unsigned                sum_words;
        int unsigned                frames_closed;
        int unsigned                flushes_dropped;

        function new();
            foreach (history[i])
                history[i] = '0;
            hist_wr         = 0;
            frame_pos       = 0;
            errors          = 0;
            border_words    = 0;
            sum_words       = 0;
            frames_closed   = 0;
            flushes_dropped = 0;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        // sample d words back from the current one
        function int tap(int unsigned d, logic signed [SAMPLE_W-1:0] cur);
            if (d == 0)
                return cur;
            return history[(hist_wr + HIST_DEPTH - d) % HIST_DEPTH];
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] ERROR %s", $time, msg);
        endfunction

        // accepted input word: advance the frame and queue the result it releases
        function void note_word(op_t op, logic [SAMPLE_W-1:0] smp);
            logic signed [SAMPLE_W-1:0] cur;
            int unsigned                c;
            int unsigned                ctr_row;
            int unsigned                ctr_col;
            int                         acc;
            bit                         on_border;
            bit                         produced;
            stencil_word_t              want;
            // flush with no frame open is dropped
            if (op == OP_FLUSH && frame_pos == 0)
            begin
                flushes_dropped++;
                return;
            end
            cur      = (op == OP_FLUSH) ? '0 : $signed(smp);
            produced = 1'b0;
            want     = '0;
            if (frame_pos >= LAG)
            begin
                c         = frame_pos - LAG;
                ctr_row   = c / SIDE;
                ctr_col   = c % SIDE;
                on_border = ctr_row < RADIUS || ctr_row >= SIDE - RADIUS ||
                            ctr_col < RADIUS || ctr_col >= SIDE - RADIUS;
                if (on_border)
                begin
                    acc = tap(LAG, cur);
                    border_words++;
                end
                else
                begin
                    // vertical and horizontal arms, centre counted once
                    acc = -tap(LAG, cur);
                    for (int k = 0; k <= 2 * RADIUS; k++)
                        acc += tap(k * SIDE + RADIUS, cur) + tap(RADIUS * SIDE + k, cur);
                    sum_words++;
                end
                want.value = acc[VALUE_W-1:0];
                want.row   = ctr_row[COORD_W-1:0];
                want.col   = ctr_col[COORD_W-1:0];
                want.last  = (c == TOTAL - 1);
                words_due.push_back(want);
                produced = 1'b1;
            end
            history[hist_wr] = cur;
            hist_wr = (hist_wr + 1) % HIST_DEPTH;
            if (produced && want.last)
            begin
                frame_pos = 0;
                frames_closed++;
            end
            else
                frame_pos++;
        endfunction

        // accepted result word: compare with the oldest prediction
        function void check_word(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            stencil_word_t got;
            stencil_word_t want;
            got.value = tdata[VALUE_W-1:0];
            got.row   = tdata[VALUE_W +: COORD_W];
            got.col   = tdata[VALUE_W + COORD_W +: COORD_W];
            got.last  = tlast;
            if (words_due.size() == 0)
            begin
                note_error($sformatf({"result word with none due: ",
                                      "value %0d row %0d col %0d last %0b"},
                                     $signed(got.value), got.row, got.col, got.last));
                return;
            end
            want = words_due.pop_front();
            if (got.value !== want.value || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
                note_error($sformatf({"expected value %0d row %0d col %0d last %0b, ",
                                      "got value %0d row %0d col %0d last %0b"},
                                     $signed(want.value), want.row, want.col, want.last,
                                     $signed(got.value), got.row, got.col, got.last));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] sample
    logic [0:0]             s_axis_tuser;   // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [19:0] value, [29:20] row, [39:30] col
    logic                   m_axis_tlast;

    stencil_scoreboard sb;
    longint            cycle_count  = 0;
    longint            held_cycles  = 0;
    int unsigned       words_sent   = 0;
    bit                sender_quiet = 1'b0;

    star_stencil_2d_radius3 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 999);
        if (r < 870)
            return 0;
        if (r < 995)
            return $urandom_range(1, 3);
        return $urandom_range(10, MAX_IDLE);
    endfunction

    // offer one word from the falling edge until taken, then idle a while
    task automatic send_word(input op_t op, input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (words_sent % 256 == 0)
            sender_quiet = ($urandom_range(0, 2) == 0);
        gap = sender_quiet ? 0 : pick_idle();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom_range(0, 16'hFFFF));
            repeat (gap) @(negedge clk);
        end
    endtask

    // word for a frame position: opening extremes, saturated patches, random fill
    function automatic void frame_word(input int unsigned pos, output op_t op,
                                       output logic [SAMPLE_W-1:0] smp);
        int unsigned r;
        int unsigned c;
        int          pick;
        r    = pos / SIDE;
        c    = pos % SIDE;
        op   = OP_PIXEL;
        pick = $urandom_range(0, 99);
        smp  = SAMPLE_W'($urandom_range(0, 16'hFFFF));
        if (pos < OPENING_N)
        begin
            case (pos)
                0:  smp = 16'h8000;
                1:  smp = 16'h7FFF;
                2:  smp = 16'h0000;
                3:  smp = 16'hFFFF;
                4:  smp = 16'h0001;
                5:  smp = 16'hAAAA;
                6:  smp = 16'h5555;
                7:  smp = 16'h8001;
                8:  smp = 16'h7FFE;
                9:  smp = 16'h00FF;
                10: smp = 16'hFF00;
                11: smp = 16'h1234;
                default: op = OP_FLUSH;   // flush inside the frame, read as zero
            endcase
        end
        else if (r >= PATCH_ROW_LO && r <= PATCH_ROW_HI && c >= 8 && c <= 16)
            smp = 16'h7FFF;   // full positive star
        else if (r >= PATCH_ROW_LO && r <= PATCH_ROW_HI && c >= 24 && c <= 32)
            smp = 16'h8000;   // full negative star
        else if (r >= PATCH_ROW_LO && r <= PATCH_ROW_HI && c >= 40 && c <= 48)
            smp = pick[0] ? 16'h7FFF : 16'h8000;
        else if (pick < 4)
            op = OP_FLUSH;
        else if (pick < 10)
        begin
            case ($urandom_range(0, 4))
                0:       smp = 16'h7FFF;
                1:       smp = 16'h8000;
                2:       smp = 16'hFFFF;
                3:       smp = 16'h0000;
                default: smp = 16'h0001;
            endcase
        end
    endfunction

    // stimulus, drain and verdict
    initial
    begin
        op_t                 op;
        logic [SAMPLE_W-1:0] smp;
        sb            = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flushes with no frame open are dropped
        for (int i = 0; i < LEAD_FLUSHES; i++)
            send_word(OP_FLUSH, SAMPLE_W'($urandom_range(0, 16'hFFFF)));
        // opening of the frame, far enough to release the first result words
        for (int unsigned pos = 0; pos < FRAME_ITEMS; pos++)
        begin
            frame_word(pos, op, smp);
            send_word(op, smp);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result words (%0d border copies, %0d star sums), %0d frame(s) closed",
                 sb.border_words + sb.sum_words, sb.border_words, sb.sum_words,
                 sb.frames_closed);
        $display("%0d words sent, %0d idle flushes dropped, %0d cycles input held off, %0d errors",
                 words_sent, sb.flushes_dropped, held_cycles, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side: ready runs, stalls and one long hold-off once results flow
    initial
    begin
        int run_len;
        int stall;
        bit held_once;
        m_axis_tready = 1'b0;
        held_once     = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // long hold-off so the result queue fills and input stalls
            if (!held_once && sb.pending() != 0)
            begin
                held_once = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(negedge clk);
            stall = $urandom_range(0, 1) ? $urandom_range(1, 3) : pick_idle();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // handshakes at the rising edge: results checked before the new input is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(op_t'(s_axis_tuser), s_axis_tdata);
            else if (s_axis_tvalid)
                held_cycles++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d result words still due",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
